// ----- sv/lsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfc_pkg: shared types and constants for the length/sum frame checker
// Holds the frame word size and the result record passed between the
// deframer and the output register.
// ----------------------------------------------------------------------------
package lsfc_pkg;

   // Bytes in the length and checksum fields, little-endian.
   localparam int WORD_BYTES = 8;
   localparam int WORD_BITS  = 8 * WORD_BYTES;
   // Byte counter inside a length or checksum field.
   localparam int COUNT_W    = 3;

   // Result kinds.
   localparam logic KIND_BODY = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Result word.
   typedef struct packed {
      logic       kind;
      logic [7:0] frame_tag;
      logic [7:0] body_byte;
      logic       checksum_ok;
      logic       last;
   } lsfc_result_type;

endpackage

// ----- sv/lsfc_in_reg.sv -----
// ----------------------------------------------------------------------------
// lsfc_in_reg: input register
// Captures one stream byte and holds it until the deframer consumes it.
// ----------------------------------------------------------------------------
module lsfc_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       consume,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   // The register is free when empty or when its word leaves this cycle.
   assign req_tready = !valid_ff || consume;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ----- sv/lsfc_deframer.sv -----
// ----------------------------------------------------------------------------
// lsfc_deframer: frame parser and checksum accumulator
// Walks type, length, body and checksum fields one byte per consumed word
// and forms at most one result per byte.
// ----------------------------------------------------------------------------
module lsfc_deframer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     consume,
   input  logic [7:0]               item_byte,
   output logic                     res_valid,
   output lsfc_pkg::lsfc_result_type result
);
   import lsfc_pkg::*;

   localparam logic [1:0] PH_TYPE = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_SUM  = 2'd3;

   logic [1:0]           phase_ff,     phase_in;
   logic [COUNT_W-1:0]   count_ff,     count_in;
   logic [WORD_BITS-1:0] remaining_ff, remaining_in;
   logic [WORD_BITS-1:0] sum_ff,       sum_in;
   logic [WORD_BITS-1:0] checksum_ff,  checksum_in;
   logic [7:0]           type_ff,      type_in;

   logic                 field_done;
   logic [WORD_BITS-1:0] byte_shifted;
   logic [WORD_BITS-1:0] length_next;
   logic [WORD_BITS-1:0] checksum_next;
   logic [WORD_BITS-1:0] remaining_dec;

   // Byte placed at its little-endian position within the current field.
   assign field_done    = (count_ff == COUNT_W'(WORD_BYTES - 1));
   assign byte_shifted  = WORD_BITS'(item_byte) << {count_ff, 3'b000};
   assign length_next   = remaining_ff | byte_shifted;
   assign checksum_next = checksum_ff | byte_shifted;
   assign remaining_dec = remaining_ff - WORD_BITS'(1);

   // Next state and result for the byte being consumed.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      checksum_in  = checksum_ff;
      type_in      = type_ff;
      res_valid    = 1'b0;
      result       = '0;
      result.frame_tag = type_ff;

      unique case (phase_ff)
         PH_TYPE: begin
            type_in      = item_byte;
            count_in     = '0;
            remaining_in = '0;
            phase_in     = PH_LEN;
         end
         PH_LEN: begin
            // The length is assembled straight into the down counter.
            remaining_in = length_next;
            if (field_done) begin
               count_in    = '0;
               sum_in      = '0;
               checksum_in = '0;
               phase_in    = (length_next == '0) ? PH_SUM : PH_BODY;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         PH_BODY: begin
            sum_in       = sum_ff + WORD_BITS'(item_byte);
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_SUM;
               count_in = '0;
            end
            res_valid        = 1'b1;
            result.kind      = KIND_BODY;
            result.body_byte = item_byte;
         end
         PH_SUM: begin
            if (!field_done) begin
               checksum_in = checksum_next;
               count_in    = count_ff + COUNT_W'(1);
            end else begin
               res_valid          = 1'b1;
               result.kind        = KIND_END;
               result.checksum_ok = (checksum_next == sum_ff);
               result.last        = 1'b1;
               // Frame done: clear everything for the next type byte.
               phase_in     = PH_TYPE;
               count_in     = '0;
               remaining_in = '0;
               sum_in       = '0;
               checksum_in  = '0;
               type_in      = '0;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         count_ff     <= '0;
         remaining_ff <= '0;
         sum_ff       <= '0;
         checksum_ff  <= '0;
         type_ff      <= '0;
      end else if (consume) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         checksum_ff  <= checksum_in;
         type_ff      <= type_in;
      end
   end

   // A body phase always has at least one byte left to take.
   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remaining_ff != '0)
      else $error("body phase entered with nothing remaining");

   // The field byte counter never passes the field size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WORD_BYTES - 1))
      else $error("field byte counter out of range");

   // A finished checksum field always returns the parser to the type byte.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      consume && res_valid && result.last |=> phase_ff == PH_TYPE && sum_ff == '0)
      else $error("frame end did not clear the parser");

endmodule

// ----- sv/lsfc_out_reg.sv -----
// ----------------------------------------------------------------------------
// lsfc_out_reg: result register
// Holds one result word for the output stream and frees itself when taken.
// ----------------------------------------------------------------------------
module lsfc_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  lsfc_pkg::lsfc_result_type result,
   output logic                      out_free,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,  // frame_tag, body_byte, checksum_ok, zero pad
   output logic [0:0]                rsp_tuser,  // kind
   output logic                      rsp_tlast
);
   import lsfc_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   lsfc_result_type result_ff;

   // A new word may enter when the register is empty or being drained.
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   // Pack the result word onto the stream ports.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, result_ff.checksum_ok, result_ff.body_byte,
                        result_ff.frame_tag};
   assign rsp_tuser  = result_ff.kind;
   assign rsp_tlast  = result_ff.last;

endmodule

// ----- sv/length_sum_frame_checker_core.sv -----
// ----------------------------------------------------------------------------
// length_sum_frame_checker_core: byte-stream deframer with additive checksum
// Takes one byte per word: a type byte, an 8-byte little-endian body length,
// the body and an 8-byte little-endian checksum. Every body byte comes out as
// a word with tuser low; after the last checksum byte one word with tuser and
// tlast high reports in tdata bit 16 whether the checksum equals the body sum
// modulo 2^64. A byte is accepted every cycle unless the output stalls; each
// result passes through the input register and the result register, and
// req_tready drops only while the result register is full and not taken.
// ----------------------------------------------------------------------------
module length_sum_frame_checker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // frame_tag, body_byte, checksum_ok, zero pad
   output logic [0:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);
   import lsfc_pkg::*;

   logic            item_valid;
   logic [7:0]      item_byte;
   logic            out_free;
   logic            consume;
   logic            res_valid;
   lsfc_result_type result;

   // The held byte is processed once the result register can take its output.
   assign consume = item_valid && out_free;

   lsfc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .consume    (consume),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   lsfc_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .item_byte (item_byte),
      .res_valid (res_valid),
      .result    (result)
   );

   lsfc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && res_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
